[sv/ddpid_pkg.sv]
// ddpid_pkg: shared types, constants and the microcode table of the dual pid unit
package ddpid_pkg;

  // configuration register file
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W    = 4;

  localparam logic [2:0] REG_DIST_P = 3'd0;
  localparam logic [2:0] REG_DIST_I = 3'd1;
  localparam logic [2:0] REG_DIST_D = 3'd2;
  localparam logic [2:0] REG_ANG_P  = 3'd3;
  localparam logic [2:0] REG_ANG_I  = 3'd4;
  localparam logic [2:0] REG_ANG_D  = 3'd5;
  localparam logic [2:0] REG_INV_R  = 3'd6;
  localparam logic [2:0] REG_HALF_R = 3'd7;

  localparam logic [31:0] Q16_ONE = 32'h0001_0000;
  localparam logic [31:0] GAIN_RESET [NUM_REGS] = '{
    Q16_ONE, 32'h0, 32'h0, Q16_ONE, 32'h0, 32'h0, Q16_ONE, Q16_ONE
  };
  localparam logic [31:0] UNSIGNED_MASK = 32'h7FFF_FFFF;

  // encoder counts to Q16.16 travel
  localparam logic [15:0] COUNT_SCALE_Q16 = 16'd43;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // request payloads
  typedef struct packed {
    logic        [15:0] left_count;
    logic        [15:0] right_count;
    logic signed [31:0] distance_target;
    logic signed [31:0] angle_target;
    logic signed [31:0] angle_measured;
  } ddpid_in_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               clipped;
  } ddpid_out_t;

  // microcode fields
  typedef enum logic [2:0] {
    ALU_NONE, ALU_EA, ALU_AINT, ALU_ADIFF, ALU_ED, ALU_DINT, ALU_DDIFF
  } alu_op_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_TRAVEL, MUL_KPA, MUL_KIA, MUL_KDA,
    MUL_KPD, MUL_KID, MUL_KDD, MUL_HALF, MUL_INV
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    MX_NONE, MX_TRAVEL, MX_W, MX_V_PW, MX_SUMS, MX_OUT
  } misc_op_t;

  typedef enum logic [1:0] {
    CND_NONE, CND_IN, CND_OUT
  } cond_t;

  typedef struct packed {
    alu_op_t  alu;
    mul_sel_t mul;
    acc_op_t  acc;
    misc_op_t misc;
    cond_t    cond;
  } ddpid_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } ddpid_stat_t;

  // microcode rom: step 0 waits for a request, last step waits for the output slot
  function automatic ddpid_ctl_t ddpid_ucode(input logic [STEP_W-1:0] step);
    ddpid_ctl_t w;
    w = '{alu: ALU_NONE, mul: MUL_NONE, acc: ACC_NONE, misc: MX_NONE, cond: CND_NONE};
    unique case (step)
      4'd0:  w.cond = CND_IN;
      4'd1:  begin w.alu = ALU_EA;    w.mul = MUL_TRAVEL; end
      4'd2:  begin w.alu = ALU_AINT;  w.mul = MUL_KPA; w.misc = MX_TRAVEL; end
      4'd3:  begin w.alu = ALU_ADIFF; w.mul = MUL_KIA; w.acc = ACC_LOAD; end
      4'd4:  begin w.alu = ALU_ED;    w.mul = MUL_KDA; w.acc = ACC_ADD; end
      4'd5:  begin w.alu = ALU_DINT;  w.mul = MUL_KPD; w.acc = ACC_ADD; end
      4'd6:  begin
        w.alu = ALU_DDIFF; w.mul = MUL_KID; w.acc = ACC_LOAD; w.misc = MX_W;
      end
      4'd7:  begin w.mul = MUL_KDD;  w.acc = ACC_ADD; end
      4'd8:  begin w.mul = MUL_HALF; w.acc = ACC_ADD; end
      4'd9:  w.misc = MX_V_PW;
      4'd10: w.mul = MUL_INV;
      4'd11: w.misc = MX_SUMS;
      4'd12: begin w.misc = MX_OUT; w.cond = CND_OUT; end
      default: w.cond = CND_OUT;
    endcase
    return w;
  endfunction

endpackage

[sv/ddpid_seq.sv]
// ddpid_seq: step counter and microcode fetch
module ddpid_seq import ddpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ddpid_stat_t stat,
  output ddpid_ctl_t  ctl,
  output logic        in_ready
);

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;

  // fetch
  assign ctl      = ddpid_ucode(pc_r);
  assign in_ready = (ctl.cond == CND_IN);

  // next step with conditional jumps
  always_comb begin
    unique case (ctl.cond)
      CND_IN:  pc_nxt = stat.in_valid ? pc_r + 1'b1 : pc_r;
      CND_OUT: pc_nxt = stat.out_free ? '0 : pc_r;
      default: pc_nxt = pc_r + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[sv/ddpid_dp.sv]
// ddpid_dp: shared multiplier, saturating adder, accumulator, loop state and registers
module ddpid_dp import ddpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddpid_ctl_t           ctl,
  input  logic                 in_load,
  input  ddpid_in_t            in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ddpid_out_t           out_data,
  output logic                 out_free
);

  // truncate toward zero by 2^16, then clamp to 16 bits; msb flags a clamp
  function automatic logic [16:0] speed_of(input logic signed [48:0] x);
    logic signed [48:0] biased;
    logic signed [32:0] s;
    logic [16:0]        r;
    biased = x + (x[48] ? 49'sd65535 : 49'sd0);
    s = biased[48:16];
    if (s > 33'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (s < -33'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, s[15:0]};
    end
    return r;
  endfunction

  logic [31:0] gain_r [NUM_REGS];

  logic [15:0]        prevl_r, prevr_r;
  logic [16:0]        dlr_r;
  logic signed [31:0] dt_r, at_r, am_r;
  logic signed [31:0] dint_r, dlast_r, aint_r, alast_r;
  logic signed [31:0] ea_r, adiff_r, ed_r, ddiff_r;
  logic signed [31:0] travel_r, w_r, v_r;
  logic signed [63:0] prod_r;
  logic signed [49:0] acc_r;
  logic signed [47:0] pw_r;
  logic signed [48:0] lsum_r, rsum_r;
  logic               clip_r;
  logic               out_valid_r;
  ddpid_out_t         out_data_r;

  logic [15:0]        dl, dr;
  logic signed [31:0] alu_x, alu_y, alu_res;
  logic               alu_sub, alu_ovf;
  logic signed [32:0] alu_sum;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_full;
  logic signed [47:0] prod_fl;
  logic               acc_fit;
  logic signed [31:0] acc_sat;
  logic               travel_ovf;
  logic [16:0]        ls_q, rs_q;
  logic               out_fire;

  // count deltas modulo 2^16
  assign dl = in_data.left_count - prevl_r;
  assign dr = in_data.right_count - prevr_r;

  // saturating add/subtract operand select
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (ctl.alu)
      ALU_EA:    begin alu_x = at_r;   alu_y = am_r;     alu_sub = 1'b1; end
      ALU_AINT:  begin alu_x = aint_r; alu_y = ea_r; end
      ALU_ADIFF: begin alu_x = ea_r;   alu_y = alast_r;  alu_sub = 1'b1; end
      ALU_ED:    begin alu_x = dt_r;   alu_y = travel_r; alu_sub = 1'b1; end
      ALU_DINT:  begin alu_x = dint_r; alu_y = ed_r; end
      ALU_DDIFF: begin alu_x = ed_r;   alu_y = dlast_r;  alu_sub = 1'b1; end
      default:   ;
    endcase
  end

  assign alu_sum = alu_sub ? ({alu_x[31], alu_x} - {alu_y[31], alu_y})
                           : ({alu_x[31], alu_x} + {alu_y[31], alu_y});
  assign alu_ovf = alu_sum[32] != alu_sum[31];
  assign alu_res = alu_ovf ? (alu_sum[32] ? S32_MIN : S32_MAX) : alu_sum[31:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.mul)
      MUL_TRAVEL: begin
        mul_a = {15'd0, dlr_r};
        mul_b = {16'd0, COUNT_SCALE_Q16};
      end
      MUL_KPA:  begin mul_a = gain_r[REG_ANG_P];  mul_b = ea_r; end
      MUL_KIA:  begin mul_a = gain_r[REG_ANG_I];  mul_b = aint_r; end
      MUL_KDA:  begin mul_a = gain_r[REG_ANG_D];  mul_b = adiff_r; end
      MUL_KPD:  begin mul_a = gain_r[REG_DIST_P]; mul_b = ed_r; end
      MUL_KID:  begin mul_a = gain_r[REG_DIST_I]; mul_b = dint_r; end
      MUL_KDD:  begin mul_a = gain_r[REG_DIST_D]; mul_b = ddiff_r; end
      MUL_HALF: begin mul_a = w_r; mul_b = gain_r[REG_HALF_R]; end
      MUL_INV:  begin mul_a = v_r; mul_b = gain_r[REG_INV_R]; end
      default:  ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // floor of product by 2^16, accumulator clamp, travel clamp
  assign prod_fl    = prod_r[63:16];
  assign acc_fit    = (&acc_r[49:31]) | ~(|acc_r[49:31]);
  assign acc_sat    = acc_fit ? acc_r[31:0] : (acc_r[49] ? S32_MIN : S32_MAX);
  assign travel_ovf = |prod_r[63:32];

  // output stage
  assign ls_q     = speed_of(lsum_r);
  assign rs_q     = speed_of(rsum_r);
  assign out_free = !out_valid_r || out_ready;
  assign out_fire = (ctl.misc == MX_OUT) && out_free;

  // configuration registers, index beyond the list ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        gain_r[i] <= GAIN_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      if (cfg_index[2:0] == REG_INV_R || cfg_index[2:0] == REG_HALF_R) begin
        gain_r[cfg_index[2:0]] <= cfg_data & UNSIGNED_MASK;
      end else begin
        gain_r[cfg_index[2:0]] <= cfg_data;
      end
    end
  end

  // loop state and clip flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prevl_r <= '0;
      prevr_r <= '0;
      dint_r  <= '0;
      dlast_r <= '0;
      aint_r  <= '0;
      alast_r <= '0;
      clip_r  <= 1'b0;
    end else begin
      if (in_load) begin
        prevl_r <= in_data.left_count;
        prevr_r <= in_data.right_count;
      end
      if (ctl.alu == ALU_AINT)  aint_r  <= alu_res;
      if (ctl.alu == ALU_ADIFF) alast_r <= ea_r;
      if (ctl.alu == ALU_DINT)  dint_r  <= alu_res;
      if (ctl.alu == ALU_DDIFF) dlast_r <= ed_r;
      if (in_load) begin
        clip_r <= 1'b0;
      end else if ((ctl.alu != ALU_NONE && alu_ovf) ||
                   (ctl.misc == MX_TRAVEL && travel_ovf) ||
                   ((ctl.misc == MX_W || ctl.misc == MX_V_PW) && !acc_fit)) begin
        clip_r <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_load) begin
      dlr_r <= {1'b0, dl} + {1'b0, dr};
      dt_r  <= in_data.distance_target;
      at_r  <= in_data.angle_target;
      am_r  <= in_data.angle_measured;
    end
    if (ctl.alu == ALU_EA)    ea_r    <= alu_res;
    if (ctl.alu == ALU_ADIFF) adiff_r <= alu_res;
    if (ctl.alu == ALU_ED)    ed_r    <= alu_res;
    if (ctl.alu == ALU_DDIFF) ddiff_r <= alu_res;
    if (ctl.mul != MUL_NONE)  prod_r  <= mul_full;
    case (ctl.acc)
      ACC_LOAD: acc_r <= 50'(prod_fl);
      ACC_ADD:  acc_r <= acc_r + 50'(prod_fl);
      default:  ;
    endcase
    case (ctl.misc)
      MX_TRAVEL: travel_r <= travel_ovf ? S32_MAX : prod_r[32:1];
      MX_W:      w_r <= acc_sat;
      MX_V_PW:   begin
        v_r  <= acc_sat;
        pw_r <= prod_fl;
      end
      MX_SUMS:   begin
        lsum_r <= {prod_fl[47], prod_fl} - {pw_r[47], pw_r};
        rsum_r <= {prod_fl[47], prod_fl} + {pw_r[47], pw_r};
      end
      default:   ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_data_r.left_speed  <= ls_q[15:0];
      out_data_r.right_speed <= rs_q[15:0];
      out_data_r.clipped     <= clip_r | ls_q[16] | rs_q[16];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/differential_drive_dual_pid_unit.sv]
// differential_drive_dual_pid_unit: top level of the microcoded dual pid wheel controller
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_ready, in_data            | in
//  result  | out_valid, out_ready, out_data         | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// a request is accepted at the wait step, then goes through twelve microcode steps that
// run every multiply through the one shared 32x32 multiplier
// the next request is accepted once the step counter is back at its wait step
// the result register frees the sequencer; it stalls on its last step only
// while a previous result still waits to be taken
// reset is synchronous; config writes are always accepted
module differential_drive_dual_pid_unit import ddpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ddpid_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ddpid_out_t           out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ddpid_ctl_t  ctl;
  ddpid_stat_t stat;
  logic        out_free;
  logic        in_load;

  assign cfg_ready     = 1'b1;
  assign in_load       = in_valid && in_ready;
  assign stat.in_valid = in_valid;
  assign stat.out_free = out_free;

  // sequencer
  ddpid_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_ready)
  );

  // datapath
  ddpid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_load   (in_load),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_free  (out_free)
  );

  // an accepted request starts the program
  assert property (@(posedge clk) disable iff (!rst_n) in_load |=> !in_ready)
    else $error("sequencer did not leave the wait step after a request");

  // a new result only comes out of the final step
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid ##1 out_valid) |-> $past(ctl.misc == MX_OUT))
    else $error("result appeared outside the output step");

  // a blocked output holds the sequencer on its final step
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.misc == MX_OUT && out_valid && !out_ready) |=> (ctl.misc == MX_OUT))
    else $error("sequencer left the output step while the result slot was full");

endmodule
